// File: sv/asr_pkg.sv
// ---------------------------------------------------------------------------
// asr_pkg: adaptive sample resampler shared types
// Transaction structs, configuration struct, register indexes, sequencer states.
// ---------------------------------------------------------------------------
`default_nettype none

package asr_pkg;

  localparam int POS_W   = 24;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  localparam logic [POS_W-1:0] POS_MAX = 24'hFFFFFF;

  localparam logic        MODE_RESET      = 1'b0;
  localparam logic [14:0] THRESHOLD_RESET = 15'd164;
  localparam logic [7:0]  INTERVAL_RESET  = 8'd255;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               block_end;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_value;
    logic [POS_W-1:0]   out_position;
    logic               run_last;
  } out_t;

  typedef struct packed {
    logic        mode;
    logic [14:0] threshold;
    logic [7:0]  change_spacing;
    logic [7:0]  deviation_spacing;
  } cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_THRESHOLD,
    REG_CHANGE_SPACING,
    REG_DEVIATION_SPACING
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOGIC,
    ST_PUSH,
    ST_DEC_CTRL,
    ST_DEC_PT,
    ST_DRAIN,
    ST_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

// File: sv/adaptive_sample_resampler.sv
// ---------------------------------------------------------------------------
// adaptive_sample_resampler: top level
// Reduces a sample stream to (value, position) points by change or deviation.
//
//   channel   dir  handshake                     payload
//   sample    in   sample_valid / sample_ready   in_t  {sample, block_end}
//   result    out  result_valid / result_ready   out_t {out_value, out_position, run_last}
//   config    in   APB psel/penable/pwrite       mode, threshold, spacings
//
// Per sample the engine sequencer steps through a first state, then the logic
// state in logic mode, or push and any due decision states in real mode, then finish.
// A block end drains each pending real-mode decision (up to 25 pending) through a
// zero push and the decision states, with extra zero pushes for blocks shorter
// than half the window, then a tail step. A low result_ready stalls the engine
// once its held-back and output result registers are full; the 4-entry queue then fills.
// Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module adaptive_sample_resampler
  import asr_pkg::*;
#(
  parameter int WINDOW_LEN = 51,
  parameter int INDEX_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  in_t         sample_item,
  output logic        result_valid,
  input  logic        result_ready,
  output out_t        result_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t      cfg;
  in_t       head;
  q_status_t q_stat;
  logic      pop;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode              <= MODE_RESET;
      cfg.threshold         <= THRESHOLD_RESET;
      cfg.change_spacing    <= INTERVAL_RESET;
      cfg.deviation_spacing <= INTERVAL_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_MODE:              cfg.mode              <= pwdata[0];
        REG_THRESHOLD:         cfg.threshold         <= pwdata[14:0];
        REG_CHANGE_SPACING:    cfg.change_spacing    <= pwdata[7:0];
        REG_DEVIATION_SPACING: cfg.deviation_spacing <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_MODE:              prdata = 32'(cfg.mode);
      REG_THRESHOLD:         prdata = 32'(cfg.threshold);
      REG_CHANGE_SPACING:    prdata = 32'(cfg.change_spacing);
      REG_DEVIATION_SPACING: prdata = 32'(cfg.deviation_spacing);
      default:               prdata = '0;
    endcase
  end

  asr_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .pop          (pop),
    .head         (head),
    .status       (q_stat)
  );

  asr_engine #(
    .WINDOW_LEN (WINDOW_LEN),
    .INDEX_BITS (INDEX_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (!q_stat.empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_stat.empty |-> !pop)
    else $error("engine popped an empty queue");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && paddr[3:2] == REG_MODE) |=> (cfg.mode == $past(pwdata[0])))
    else $error("mode register write lost");

  a_full_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_stat.full && !pop) |=> q_stat.full)
    else $error("queue left full state without a pop");

endmodule

`default_nettype wire

// File: sv/asr_queue.sv
// ---------------------------------------------------------------------------
// asr_queue: input queue
// Accepts sample transactions and holds them for the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module asr_queue
  import asr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      sample_valid,
  output logic      sample_ready,
  input  in_t       sample_item,
  input  logic      pop,
  output in_t       head,
  output q_status_t status
);

  in_t                q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               push;

  assign status.empty = (count == '0);
  assign status.full  = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign sample_ready = !status.full;
  assign push         = sample_valid && sample_ready;
  assign head         = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= sample_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/asr_engine.sv
// ---------------------------------------------------------------------------
// asr_engine: resampling sequencer
// Runs logic and real mode decisions per sample and stages result transactions.
// ---------------------------------------------------------------------------
`default_nettype none

module asr_engine
  import asr_pkg::*;
#(
  parameter int WINDOW_LEN = 51,
  parameter int INDEX_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic q_valid,
  input  in_t  head,
  output logic pop,
  output logic result_valid,
  input  logic result_ready,
  output out_t result_item
);

  localparam int HALF   = WINDOW_LEN / 2;
  localparam int SPAN   = 2 * HALF + 1;
  localparam int SUM_W  = $clog2(SPAN) + 16;
  localparam int DIFF_W = SUM_W + 2;
  localparam int CNT_W  = $clog2(SPAN + 1);
  localparam logic [INDEX_BITS-1:0]    IDX_MAX = '1;
  localparam logic signed [DIFF_W-1:0] WL_S    = DIFF_W'(WINDOW_LEN);
  localparam logic [DIFF_W-1:0]        WL_U    = DIFF_W'(WINDOW_LEN);

  function automatic logic [INDEX_BITS-1:0] sat_inc(input logic [INDEX_BITS-1:0] v);
    return (v == IDX_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [POS_W-1:0] clamp_pos(input logic [INDEX_BITS-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return (w > 32'(POS_MAX)) ? POS_MAX : w[POS_W-1:0];
  endfunction

  seq_state_t state, state_next;

  in_t                     cur;
  logic signed [15:0]      hist [SPAN];
  logic signed [SUM_W-1:0] wsum;
  logic [INDEX_BITS-1:0]   sidx, cidx, didx;
  logic signed [15:0]      prev;
  logic                    started, bmode, first_r, fire_r;
  logic [CNT_W-1:0]        undec, depth;

  logic                    pend_valid;
  logic signed [15:0]      pend_value;
  logic [POS_W-1:0]        pend_pos;

  logic signed [DIFF_W-1:0] scaled, diff, mag;
  logic [DIFF_W-1:0]        limit;
  logic                     dev;
  logic [CNT_W-1:0]         depth_push;
  logic                     ctrl_due, tail_due;
  logic                     want, flush, emit_ok, go;
  logic signed [15:0]       emit_value;
  logic [INDEX_BITS-1:0]    emit_idx;
  logic                     out_free;
  logic signed [15:0]       push_x;
  logic                     do_push;

  assign scaled = DIFF_W'(hist[HALF]) * WL_S;
  assign diff   = scaled - DIFF_W'(wsum);
  assign mag    = diff[DIFF_W-1] ? -diff : diff;
  assign limit  = WL_U * DIFF_W'(cfg.threshold);
  assign dev    = $unsigned(mag) > limit;

  assign depth_push = (undec != '0) ? depth + 1'b1 : '0;
  assign ctrl_due   = ({1'b0, cidx} + 1'b1) < {1'b0, didx};
  assign tail_due   = ctrl_due;

  assign out_free = !result_valid || result_ready;
  assign emit_ok  = !pend_valid || out_free;

  always_comb begin
    want       = 1'b0;
    flush      = 1'b0;
    pop        = 1'b0;
    emit_value = cur.sample;
    emit_idx   = '0;
    unique case (state)
      ST_IDLE: begin
        pop = q_valid;
      end
      ST_FIRST: begin
        want = !started;
      end
      ST_LOGIC: begin
        want     = !first_r && ((cur.sample != prev) ||
                   (INDEX_BITS'(sidx - cidx) >= INDEX_BITS'(cfg.change_spacing)));
        emit_idx = sidx;
      end
      ST_PUSH: begin
      end
      ST_DEC_CTRL: begin
        want       = dev && ctrl_due;
        emit_value = prev;
        emit_idx   = didx - 1'b1;
      end
      ST_DEC_PT: begin
        want       = fire_r;
        emit_value = hist[HALF];
        emit_idx   = didx;
      end
      ST_DRAIN: begin
        want       = (undec == '0) && tail_due;
        emit_value = prev;
        emit_idx   = didx - 1'b1;
      end
      ST_FINISH: begin
        flush = 1'b1;
      end
      default: begin
      end
    endcase
    go = !(want || flush) || emit_ok;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (go) state_next = (started ? bmode : cfg.mode) ? ST_PUSH : ST_LOGIC;
      end
      ST_LOGIC: begin
        if (go) state_next = ST_FINISH;
      end
      ST_PUSH: begin
        if (depth_push == CNT_W'(HALF)) state_next = ST_DEC_CTRL;
        else if (cur.block_end)          state_next = ST_DRAIN;
        else                             state_next = ST_FINISH;
      end
      ST_DEC_CTRL: begin
        if (go) state_next = ST_DEC_PT;
      end
      ST_DEC_PT: begin
        if (go) state_next = cur.block_end ? ST_DRAIN : ST_FINISH;
      end
      ST_DRAIN: begin
        if (undec != '0) begin
          if (depth + 1'b1 == CNT_W'(HALF)) state_next = ST_DEC_CTRL;
        end else if (go) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign do_push = (state == ST_PUSH) || ((state == ST_DRAIN) && (undec != '0));
  assign push_x  = (state == ST_PUSH) ? cur.sample : '0;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      for (int i = 0; i < SPAN; i++) hist[i] <= '0;
      wsum    <= '0;
      sidx    <= '0;
      cidx    <= '0;
      didx    <= '0;
      prev    <= '0;
      started <= 1'b0;
      bmode   <= 1'b0;
      first_r <= 1'b0;
      fire_r  <= 1'b0;
      undec   <= '0;
      depth   <= '0;
    end else begin
      state <= state_next;
      if (do_push) begin
        hist[0] <= push_x;
        for (int i = 1; i < SPAN; i++) hist[i] <= hist[i-1];
        wsum <= wsum + SUM_W'(push_x) - SUM_W'(hist[SPAN-1]);
      end
      if (go) begin
        unique case (state)
          ST_FIRST: begin
            first_r <= !started;
            if (!started) begin
              started <= 1'b1;
              bmode   <= cfg.mode;
              sidx    <= '0;
              cidx    <= '0;
              didx    <= '0;
              prev    <= cur.sample;
            end
          end
          ST_LOGIC: begin
            if (want) begin
              prev <= cur.sample;
              cidx <= sidx;
            end
            sidx <= sat_inc(sidx);
          end
          ST_PUSH: begin
            undec <= undec + 1'b1;
            depth <= depth_push;
            sidx  <= sat_inc(sidx);
          end
          ST_DEC_CTRL: begin
            fire_r <= dev ||
                      (INDEX_BITS'(didx - cidx) >= INDEX_BITS'(cfg.deviation_spacing));
          end
          ST_DEC_PT: begin
            if (fire_r) cidx <= didx;
            prev  <= hist[HALF];
            didx  <= sat_inc(didx);
            undec <= undec - 1'b1;
            if (depth != '0) depth <= depth - 1'b1;
          end
          ST_DRAIN: begin
            if (undec != '0) depth <= depth + 1'b1;
          end
          ST_FINISH: begin
            if (cur.block_end) begin
              for (int i = 0; i < SPAN; i++) hist[i] <= '0;
              wsum    <= '0;
              sidx    <= '0;
              cidx    <= '0;
              didx    <= '0;
              prev    <= '0;
              started <= 1'b0;
              bmode   <= 1'b0;
              undec   <= '0;
              depth   <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // one result held back so run_last can be set when the item completes
  always_ff @(posedge clk) begin
    if (want && go) begin
      pend_value <= emit_value;
      pend_pos   <= clamp_pos(emit_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pend_valid && ((want && go) || (flush && go))) begin
        result_valid <= 1'b1;
        result_item  <= '{out_value: pend_value, out_position: pend_pos,
                          run_last: flush};
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (want && go) begin
        pend_valid <= 1'b1;
      end else if (flush && go) begin
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: adaptive sample resampler testbench
// Drives sample blocks in logic and real mode over several register settings,
// predicts the emitted points in-bench and checks every result transaction.
// ---------------------------------------------------------------------------
module tb;
  import asr_pkg::*;

  localparam int WIN      = 51;
  localparam int HALF_W   = WIN / 2;
  localparam int SPAN     = 2 * HALF_W + 1;
  localparam longint IMAX = (64'd1 << 24) - 1;
  localparam int LIMIT    = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        sample_valid = 0;
  logic        sample_ready;
  in_t         sample_item = '0;
  logic        result_valid;
  logic        result_ready = 0;
  out_t        result_item;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  adaptive_sample_resampler uut (.*);

  always #5 clk = ~clk;

  in_t  pend_q[$];
  out_t points_q[$];
  bit   calm = 0;
  bit   failed = 0;
  int   cycles = 0;

  // shadow registers and block state
  bit     cf_mode;
  int     cf_thr, cf_lint, cf_rint;
  int     hist[SPAN];
  int     wsum, prev_val;
  longint s_idx, c_idx, d_idx;
  bit     started, b_mode;
  int     undec, odepth, n_pts;

  function automatic longint sat_inc(longint v);
    return v < IMAX ? v + 1 : v;
  endfunction

  function automatic void add_point(int v, longint pos);
    out_t o;
    o.out_value    = v[15:0];
    o.out_position = pos > IMAX ? POS_MAX : pos[23:0];
    o.run_last     = 1'b0;
    points_q.push_back(o);
    n_pts++;
  endfunction

  function automatic void shift_in(int x);
    int gone;
    gone = hist[SPAN-1];
    for (int i = SPAN - 1; i > 0; i--) hist[i] = hist[i-1];
    hist[0] = x;
    wsum += x - gone;
  endfunction

  function automatic void judge();
    int     v;
    longint diff;
    bit     dev;
    v = hist[HALF_W];
    diff = longint'(WIN) * v - wsum;
    if (diff < 0) diff = -diff;
    dev = diff > longint'(WIN) * cf_thr;
    if (dev || d_idx - c_idx >= cf_rint) begin
      if (dev && c_idx + 1 < d_idx) add_point(prev_val, d_idx - 1);
      add_point(v, d_idx);
      c_idx = d_idx;
    end
    prev_val = v;
    d_idx = sat_inc(d_idx);
    undec--;
    if (odepth > 0) odepth--;
  endfunction

  function automatic void close_block();
    foreach (hist[i]) hist[i] = 0;
    wsum = 0; s_idx = 0; c_idx = 0; d_idx = 0; prev_val = 0;
    started = 0; b_mode = 0; undec = 0; odepth = 0;
  endfunction

  function automatic void predict_points(in_t it);
    int v;
    bit first;
    v = it.sample;
    first = !started;
    n_pts = 0;
    if (first) begin
      started = 1; b_mode = cf_mode;
      s_idx = 0; c_idx = 0; d_idx = 0; prev_val = v;
      add_point(v, 0);
    end
    if (!b_mode) begin
      if (!first && (v != prev_val || s_idx - c_idx >= cf_lint)) begin
        add_point(v, s_idx);
        prev_val = v;
        c_idx = s_idx;
      end
      s_idx = sat_inc(s_idx);
    end else begin
      shift_in(v);
      odepth = undec ? odepth + 1 : 0;
      undec++;
      s_idx = sat_inc(s_idx);
      if (odepth == HALF_W) judge();
      if (it.block_end) begin
        while (undec > 0) begin
          shift_in(0);
          odepth++;
          if (odepth == HALF_W) judge();
        end
        if (c_idx + 1 < d_idx) add_point(prev_val, d_idx - 1);
      end
    end
    if (it.block_end) close_block();
    if (n_pts > 0) points_q[$].run_last = 1'b1;
  endfunction

  // driver
  bit took = 0;
  int in_gap = 0, out_gap = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (!(sample_valid && !took)) begin
        if (in_gap > 0) begin
          in_gap--;
          sample_valid <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 13) - 1;
          sample_valid <= 0;
        end else if (pend_q.size() > 0) begin
          sample_item  <= pend_q.pop_front();
          sample_valid <= 1;
        end else begin
          sample_valid <= 0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        result_ready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 13) - 1;
        result_ready <= 0;
      end else begin
        result_ready <= 1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles++;
    took <= sample_valid && sample_ready;
    if (!rst && sample_valid && sample_ready) predict_points(sample_item);
    if (!rst && result_valid && result_ready) begin
      if (points_q.size() == 0) begin
        $display("%0t: unexpected result exp none act %p", $time, result_item);
        failed = 1;
      end else begin
        out_t e;
        e = points_q.pop_front();
        if (e.out_value !== result_item.out_value)
          $display("%0t: out_value exp %0d act %0d", $time,
                   e.out_value, result_item.out_value);
        if (e.out_position !== result_item.out_position)
          $display("%0t: out_position exp %0d act %0d", $time,
                   e.out_position, result_item.out_position);
        if (e.run_last !== result_item.run_last)
          $display("%0t: run_last exp %0b act %0b", $time,
                   e.run_last, result_item.run_last);
        if (e !== result_item) failed = 1;
      end
    end
    if (cycles > LIMIT) begin
      $display("adaptive_sample_resampler test failed");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, int val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 4'(4 * int'(idx)); pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_MODE:              cf_mode = val[0];
      REG_THRESHOLD:         cf_thr  = val & 32'h7FFF;
      REG_CHANGE_SPACING:    cf_lint = val & 32'hFF;
      REG_DEVIATION_SPACING: cf_rint = val & 32'hFF;
      default: ;
    endcase
  endtask

  task automatic settle();
    while (pend_q.size() > 0 || sample_valid || points_q.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic put(int v, bit last);
    in_t it;
    it.sample = v[15:0];
    it.block_end = last;
    pend_q.push_back(it);
  endtask

  task automatic rand_block(int len);
    int level, style;
    level = $urandom_range(0, 65535) - 32768;
    style = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0) level = $urandom_range(0, 65535) - 32768;
      case (style)
        0: put($urandom_range(0, 65535) - 32768, i == len - 1);
        1: put(level, i == len - 1);
        default: begin
          int x;
          x = level + $urandom_range(0, 400) - 200;
          if (x > 32767) x = 32767;
          if (x < -32768) x = -32768;
          put(x, i == len - 1);
        end
      endcase
    end
  endtask

  initial begin
    int total;
    cf_mode = MODE_RESET; cf_thr = THRESHOLD_RESET;
    cf_lint = INTERVAL_RESET; cf_rint = INTERVAL_RESET;
    close_block();
    repeat (9) @(posedge clk);
    rst <= 0;

    // logic mode at reset settings: extremes and repeats
    put(-32768, 0); put(32767, 0); put(32767, 0); put(0, 0); put(-1, 0);
    put(-1, 1);
    settle();
    // mode change while a logic block is open takes effect next block
    reg_write(REG_CHANGE_SPACING, 1);
    put(5, 0); put(5, 0);
    settle();
    reg_write(REG_MODE, 1);
    put(5, 0); put(7, 1);
    // real mode, zero threshold, single sample block and short block
    settle();
    reg_write(REG_THRESHOLD, 0);
    reg_write(REG_DEVIATION_SPACING, 1);
    put(32767, 1);
    put(-32768, 0); put(100, 0); put(32767, 1);
    settle();
    reg_write(REG_THRESHOLD, 32767);
    reg_write(REG_DEVIATION_SPACING, 255);
    put(1000, 0); put(-1000, 0); put(0, 1);
    settle();

    total = 0;
    while (total < 413) begin
      int len;
      if (total > 360) calm = 1;
      reg_write(REG_MODE, $urandom_range(0, 1));
      reg_write(REG_THRESHOLD, $urandom_range(0, 3) == 0 ?
                $urandom_range(0, 32767) : $urandom_range(0, 600));
      reg_write(REG_CHANGE_SPACING, $urandom_range(0, 3) == 0 ?
                255 : $urandom_range(1, 20));
      reg_write(REG_DEVIATION_SPACING, $urandom_range(0, 3) == 0 ?
                255 : $urandom_range(1, 40));
      for (int b = 0; b < 3 && total < 413; b++) begin
        len = $urandom_range(0, 4) == 0 ? $urandom_range(1, 6) : $urandom_range(10, 60);
        rand_block(len);
        total += len;
      end
      settle();
    end

    if (!failed && points_q.size() == 0) begin
      $display("adaptive_sample_resampler test passed");
    end else begin
      $display("adaptive_sample_resampler test failed");
    end
    $finish;
  end
endmodule

// File: adaptive_sample_resampler.f
sv/asr_pkg.sv
sv/asr_queue.sv
sv/asr_engine.sv
sv/adaptive_sample_resampler.sv
dv/tb.sv
